// ===== rtl/unsigned_to_decimal_ascii_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for unsigned_to_decimal_ascii
// Shared concurrent assertion forms used by the checker.
// ----------------------------------------------------------------------------
`ifndef UNSIGNED_TO_DECIMAL_ASCII_ASSERT_SVH
`define UNSIGNED_TO_DECIMAL_ASCII_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define U2DA_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define U2DA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

// Next-cycle implication that is also checked across reset.
`define U2DA_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/u2da_pkg.sv =====
// ----------------------------------------------------------------------------
// u2da_pkg
// Types, constants and helper functions for the decimal ASCII converter.
// ----------------------------------------------------------------------------
package u2da_pkg;

  localparam int unsigned ValueWidth  = 32;
  localparam int unsigned NumDigits   = 10;
  localparam int unsigned BcdWidth    = 4 * NumDigits;
  localparam int unsigned BitsPerStep = 4;
  localparam int unsigned NumSteps    = ValueWidth / BitsPerStep;
  localparam int unsigned StepCntW    = $clog2(NumSteps);
  localparam int unsigned IdxW        = 4;
  localparam int unsigned CharWidth   = 6;

  localparam logic [IdxW-1:0]    UnitsIdx     = IdxW'(NumDigits - 1);
  localparam logic [1:0]         AsciiZeroTop = 2'b11;
  localparam logic [StepCntW-1:0] LastStep    = StepCntW'(NumSteps - 1);

  typedef logic [BcdWidth-1:0] bcd_t;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_CONV,
    FR_DONE
  } front_state_t;

  typedef struct packed {
    bcd_t            digits;
    logic [IdxW-1:0] start;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic nonempty;
  } q_status_t;

  // Four shift-and-add-three iterations of the double dabble conversion.
  function automatic bcd_t dabble_step(input bcd_t bcd_in,
                                       input logic [BitsPerStep-1:0] bits);
    bcd_t       b;
    logic [3:0] d;
    b = bcd_in;
    for (int s = 0; s < BitsPerStep; s++) begin
      for (int k = 0; k < NumDigits; k++) begin
        d = b[4*k +: 4];
        if (d >= 4'd5) begin
          b[4*k +: 4] = d + 4'd3;
        end
      end
      b = {b[BcdWidth-2:0], bits[BitsPerStep-1-s]};
    end
    return b;
  endfunction

  // Position of the first non-zero digit from the billions place; units if none.
  function automatic logic [IdxW-1:0] lead_index(input bcd_t bcd_in);
    logic [IdxW-1:0] idx;
    idx = UnitsIdx;
    for (int i = NumDigits - 1; i >= 0; i--) begin
      if (bcd_in[BcdWidth-1-4*i -: 4] != 4'd0) begin
        idx = IdxW'(i);
      end
    end
    return idx;
  endfunction

endpackage

// ===== rtl/u2da_fifo.sv =====
// ----------------------------------------------------------------------------
// u2da_fifo
// Short queue of converted values between the front and back parts.
// ----------------------------------------------------------------------------
module u2da_fifo
  import u2da_pkg::*;
#(
  parameter int unsigned Depth = 2
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  q_entry_t  push_data,
  input  logic      pop,
  output q_entry_t  pop_data,
  output q_status_t status
);

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  q_entry_t             mem [Depth];
  logic [AddrW-1:0]     wr_ptr;
  logic [AddrW-1:0]     rd_ptr;
  logic [CntW-1:0]      count;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AddrW'(Depth - 1)) ? '0 : wr_ptr + AddrW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AddrW'(Depth - 1)) ? '0 : rd_ptr + AddrW'(1);
      end
      if (push && !pop) begin
        count <= count + CntW'(1);
      end else if (pop && !push) begin
        count <= count - CntW'(1);
      end
    end
  end

  assign pop_data        = mem[rd_ptr];
  assign status.full     = (count == CntW'(Depth));
  assign status.nonempty = (count != '0);

endmodule

// ===== rtl/u2da_front.sv =====
// ----------------------------------------------------------------------------
// u2da_front
// Takes input values, converts them to packed BCD four bits a cycle and marks
// the first significant digit.
// ----------------------------------------------------------------------------
module u2da_front
  import u2da_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [ValueWidth-1:0] in_value,
  input  q_status_t             q_status,
  output logic                  push,
  output q_entry_t              push_data
);

  front_state_t          state;
  front_state_t          state_next;
  logic [StepCntW-1:0]   step_cnt;
  logic [ValueWidth-1:0] bin;
  bcd_t                  bcd;
  logic                  take;

  always_comb begin
    state_next = state;
    unique case (state)
      FR_IDLE: begin
        if (in_valid) begin
          state_next = FR_CONV;
        end
      end
      FR_CONV: begin
        if (step_cnt == LastStep) begin
          state_next = FR_DONE;
        end
      end
      FR_DONE: begin
        if (!q_status.full) begin
          state_next = in_valid ? FR_CONV : FR_IDLE;
        end
      end
      default: state_next = FR_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    push     = 1'b0;
    unique case (state)
      FR_IDLE: in_ready = 1'b1;
      FR_CONV: in_ready = 1'b0;
      FR_DONE: begin
        push     = !q_status.full;
        in_ready = !q_status.full;
      end
      default: in_ready = 1'b0;
    endcase
  end

  assign take = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= FR_IDLE;
      step_cnt <= '0;
    end else begin
      state <= state_next;
      if (take) begin
        step_cnt <= '0;
      end else if (state == FR_CONV) begin
        step_cnt <= step_cnt + StepCntW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      bin <= in_value;
      bcd <= '0;
    end else if (state == FR_CONV) begin
      bcd <= dabble_step(bcd, bin[ValueWidth-1 -: BitsPerStep]);
      bin <= {bin[ValueWidth-BitsPerStep-1:0], {BitsPerStep{1'b0}}};
    end
  end

  assign push_data.digits = bcd;
  assign push_data.start  = lead_index(bcd);

endmodule

// ===== rtl/u2da_back.sv =====
// ----------------------------------------------------------------------------
// u2da_back
// Emits the significant digits of each queued value as ASCII characters,
// most significant first, one per output transfer.
// ----------------------------------------------------------------------------
module u2da_back
  import u2da_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  q_status_t            q_status,
  input  q_entry_t             pop_data,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [CharWidth-1:0] digit_char,
  output logic                 last
);

  logic            active;
  bcd_t            digits;
  logic [IdxW-1:0] idx;
  logic            is_last;
  logic            advance;

  assign is_last = (idx == UnitsIdx);
  assign advance = active && out_ready;
  assign pop     = q_status.nonempty && (!active || (out_ready && is_last));

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (pop) begin
      active <= 1'b1;
    end else if (advance && is_last) begin
      active <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      digits <= pop_data.digits << {pop_data.start, 2'b00};
      idx    <= pop_data.start;
    end else if (advance) begin
      digits <= {digits[BcdWidth-5:0], 4'd0};
      idx    <= idx + IdxW'(1);
    end
  end

  assign out_valid  = active;
  assign digit_char = {AsciiZeroTop, digits[BcdWidth-1 -: 4]};
  assign last       = is_last;

endmodule

// ===== rtl/unsigned_to_decimal_ascii.sv =====
// ----------------------------------------------------------------------------
// unsigned_to_decimal_ascii
// Converts 32-bit unsigned values to decimal ASCII characters, most
// significant first, with leading zeros suppressed.
//
//   Channel  Handshake             Payload
//   input    in_valid / in_ready   value[31:0]
//   output   out_valid / out_ready digit_char[5:0], last
//
// The front loads a value on its input transfer and converts it in eight
// double dabble steps of four bits each. The back emits one character per
// cycle while out_ready is high, one to ten per value. Reset clears the
// control state only; an input is taken the cycle after. The queue lets
// the front keep converting while the output is stalled.
// ----------------------------------------------------------------------------
module unsigned_to_decimal_ascii
  import u2da_pkg::*;
#(
  parameter int unsigned QueueDepth = 2
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [ValueWidth-1:0] value,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [CharWidth-1:0]  digit_char,
  output logic                  last
);

  q_status_t q_status;
  q_entry_t  push_data;
  q_entry_t  pop_data;
  logic      push;
  logic      pop;

  u2da_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_value  (value),
    .q_status  (q_status),
    .push      (push),
    .push_data (push_data)
  );

  u2da_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .status    (q_status)
  );

  u2da_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_status   (q_status),
    .pop_data   (pop_data),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .digit_char (digit_char),
    .last       (last)
  );

endmodule

// ===== rtl/u2da_checker.sv =====
// ----------------------------------------------------------------------------
// u2da_checker
// Port-level checks on the converter, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "unsigned_to_decimal_ascii_assert.svh"

module u2da_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [5:0]  digit_char,
  input logic        last
);

  `U2DA_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(digit_char) && $stable(last))
  `U2DA_ASSERT_SAME(a_digit_range, clk, rst, out_valid, digit_char[5:4] == 2'b11 && digit_char[3:0] <= 4'd9)
  `U2DA_ASSERT_NEXT_ALWAYS(a_reset_idle, clk, rst, !out_valid)
  `U2DA_ASSERT_NEXT(a_busy_after_take, clk, rst, in_valid && in_ready, !in_ready)

endmodule

bind unsigned_to_decimal_ascii u2da_checker u_u2da_checker (.*);

// ===== sim/unsigned_to_decimal_ascii_check.sv =====
// ----------------------------------------------------------------------------
// unsigned_to_decimal_ascii_check
// Watches both channels of the decimal ASCII converter. Every input transfer
// queues the characters its value should produce, and every output transfer
// is compared field by field with the oldest queued character.
// ----------------------------------------------------------------------------
module unsigned_to_decimal_ascii_check
  import u2da_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [ValueWidth-1:0] value,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [CharWidth-1:0]  digit_char,
  input  logic                  last,
  output int                    pending,
  output int                    failures
);

  localparam logic [CharWidth-1:0] AsciiZero = CharWidth'(48);

  typedef struct packed {
    logic [CharWidth-1:0] ch;
    logic                 last;
  } text_char_t;

  text_char_t chars_due[$];
  int         mismatches = 0;

  function automatic void queue_decimal_text(input logic [ValueWidth-1:0] v);
    logic [3:0]            dec [NumDigits];
    logic [ValueWidth-1:0] rem;
    bit                    seen;
    text_char_t            c;
    rem  = v;
    seen = 1'b0;
    for (int i = 0; i < NumDigits; i++) begin
      dec[i] = 4'(rem % 10);
      rem    = rem / 10;
    end
    // Leading zeros are dropped, but the units place is always sent.
    for (int i = NumDigits - 1; i >= 0; i--) begin
      if (dec[i] != 4'd0) begin
        seen = 1'b1;
      end
      if (seen || i == 0) begin
        c.ch   = AsciiZero + CharWidth'(dec[i]);
        c.last = (i == 0);
        chars_due.push_back(c);
      end
    end
  endfunction

  always @(posedge clk) begin
    text_char_t want;
    if (!rst) begin
      if (in_valid && in_ready) begin
        queue_decimal_text(value);
      end
      if (out_valid && out_ready) begin
        if (chars_due.size() == 0) begin
          $display("%0t: unexpected character %0d last %0b", $time, digit_char, last);
          mismatches++;
        end else begin
          want = chars_due.pop_front();
          if (digit_char !== want.ch) begin
            $display("%0t: digit_char expected %0d actual %0d", $time, want.ch, digit_char);
            mismatches++;
          end
          if (last !== want.last) begin
            $display("%0t: last expected %0b actual %0b", $time, want.last, last);
            mismatches++;
          end
        end
      end
    end
    pending  <= chars_due.size();
    failures <= mismatches;
  end

endmodule

// ===== sim/unsigned_to_decimal_ascii_tb.sv =====
// ----------------------------------------------------------------------------
// unsigned_to_decimal_ascii_tb
// Drives the decimal ASCII converter with directed edge values and then with
// random values of every decimal length, under several patterns of sender
// idling and receiver stalling. The checker predicts and compares; this top
// gives the verdict.
// ----------------------------------------------------------------------------
module unsigned_to_decimal_ascii_tb
  import u2da_pkg::*;
;

  logic                  clk        = 1'b0;
  logic                  rst        = 1'b1;
  logic                  in_valid   = 1'b0;
  logic                  in_ready;
  logic [ValueWidth-1:0] value      = '0;
  logic                  out_valid;
  logic                  out_ready  = 1'b0;
  logic [CharWidth-1:0]  digit_char;
  logic                  last;
  int                    pending;
  int                    failures;
  int                    idle_pct   = 0;
  int                    stall_pct  = 0;
  int                    idle_set[4]  = '{0, 49, 0, 8};
  int                    stall_set[4] = '{0, 0, 49, 8};

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  unsigned_to_decimal_ascii dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .value      (value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .digit_char (digit_char),
    .last       (last)
  );

  unsigned_to_decimal_ascii_check u_check (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .value      (value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .digit_char (digit_char),
    .last       (last),
    .pending    (pending),
    .failures   (failures)
  );

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic send_value(input logic [ValueWidth-1:0] v);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    value    <= v;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain_text;
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  logic [ValueWidth-1:0] edge_values[] = '{
    32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'd101, 32'd1000000,
    32'd999999999, 32'd1000000000, 32'd1000000001, 32'd2147483648,
    32'd4000000000, 32'd4294967295, 32'h5555_5555, 32'hAAAA_AAAA,
    32'd4294967290, 32'd3000000005
  };

  initial begin
    int    ndig;
    longint lo;
    longint hi;
    logic [ValueWidth-1:0] v;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (edge_values[i]) begin
      send_value(edge_values[i]);
    end
    // Hold the sender back until the whole directed batch has been emitted.
    drain_text();

    for (int p = 0; p < 4; p++) begin
      idle_pct  = idle_set[p];
      stall_pct = stall_set[p];
      for (int n = 0; n < 33; n++) begin
        case ($urandom_range(3))
          0: v = $urandom;
          1: begin
            ndig = $urandom_range(10, 1);
            lo   = 1;
            for (int k = 1; k < ndig; k++) begin
              lo = lo * 10;
            end
            hi = lo * 10 - 1;
            if (ndig == 1) begin
              lo = 0;
            end
            if (hi > 64'd4294967295) begin
              hi = 64'd4294967295;
            end
            v = $urandom_range(ValueWidth'(hi), ValueWidth'(lo));
          end
          2: begin
            v = ValueWidth'($urandom_range(9, 1));
            for (int k = $urandom_range(9); k > 0; k--) begin
              v = v * 10;
            end
            v = v + ValueWidth'($urandom_range(9));
          end
          default: v = $urandom_range(20);
        endcase
        send_value(v);
      end
    end

    drain_text();
    repeat (16) @(posedge clk);
    if (failures == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/u2da_pkg.sv
rtl/u2da_fifo.sv
rtl/u2da_front.sv
rtl/u2da_back.sv
rtl/unsigned_to_decimal_ascii.sv
rtl/u2da_checker.sv
sim/unsigned_to_decimal_ascii_check.sv
sim/unsigned_to_decimal_ascii_tb.sv
